@@ hdl/pdlf_pkg.sv @@
// Shared widths, codes and types of the PD line-follow motor mix block.
package pdlf_pkg;

   localparam int POS_W      = 12;  // line position sample
   localparam int ERR_W      = 12;  // saturated error
   localparam int DERIV_W    = 13;  // error difference
   localparam int GAIN_W     = 7;   // gain numerator / denominator
   localparam int SPEED_W    = 8;   // motor speed and limit
   localparam int CENTER_W   = 15;  // center position range 0..32767
   localparam int PROD_W     = DERIV_W + GAIN_W + 1;  // signed product
   localparam int MAG_W      = PROD_W - 1;            // product magnitude
   localparam int QUOT_W     = MAG_W;                 // quotient bits
   localparam int SUM_W      = QUOT_W + 2;            // signed sum of two terms
   localparam int DIFF_W     = SPEED_W + 1;           // clamped drive difference
   localparam int DIV_CNT_W  = $clog2(QUOT_W + 1);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = SPEED_W;

   localparam int CENTER_DEFAULT = 2000;
   localparam logic [SPEED_W-1:0] SPEED_RESET = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE      = 3'd0,
      CSR_SPEED_LIMIT = 3'd1,
      CSR_PROP_NUM    = 3'd2,
      CSR_PROP_DEN    = 3'd3,
      CSR_DERIV_NUM   = 3'd4,
      CSR_DERIV_DEN   = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_DIV_P,
      ST_MUL_D,
      ST_DIV_D,
      ST_MIX
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ hdl/pdlf_req_if.sv @@
// Request channel: one line position sample per beat.
interface pdlf_req_if;
   logic                          valid;
   logic                          ready;
   logic [pdlf_pkg::POS_W-1:0]    sensor_pos;

   modport source (output valid, output sensor_pos, input ready);
   modport sink   (input valid, input sensor_pos, output ready);
endinterface

@@ hdl/pdlf_rsp_if.sv @@
// Response channel: two motor speeds and a halt flag per beat.
interface pdlf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pdlf_pkg::SPEED_W-1:0]  left_speed;
   logic [pdlf_pkg::SPEED_W-1:0]  right_speed;
   logic                          halted;

   modport source (output valid, output left_speed, output right_speed, output halted,
                   input ready);
   modport sink   (input valid, input left_speed, input right_speed, input halted,
                   output ready);
endinterface

@@ hdl/pdlf_div.sv @@
// Iterative restoring divider, one quotient bit per cycle, unsigned operands.
module pdlf_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [pdlf_pkg::MAG_W-1:0]      dividend,
   input  logic [pdlf_pkg::GAIN_W-1:0]     divisor,
   output logic [pdlf_pkg::QUOT_W-1:0]     quotient,
   output pdlf_pkg::div_status_type        status
);

   logic [pdlf_pkg::QUOT_W-1:0]    quot_ff, quot_in;
   logic [pdlf_pkg::GAIN_W-1:0]    rem_ff, rem_in;
   logic [pdlf_pkg::GAIN_W-1:0]    dsr_ff, dsr_in;
   logic [pdlf_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [pdlf_pkg::GAIN_W:0]      rem_shift;
   logic [pdlf_pkg::GAIN_W+1:0]    trial;

   assign rem_shift = {rem_ff, quot_ff[pdlf_pkg::QUOT_W-1]};
   assign trial     = {1'b0, rem_shift} - {2'b00, dsr_ff};

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = pdlf_pkg::DIV_CNT_W'(pdlf_pkg::QUOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // subtract when the shifted remainder covers the divisor
         if (!trial[pdlf_pkg::GAIN_W+1]) begin
            rem_in = trial[pdlf_pkg::GAIN_W-1:0];
         end else begin
            rem_in = rem_shift[pdlf_pkg::GAIN_W-1:0];
         end
         quot_in = {quot_ff[pdlf_pkg::QUOT_W-2:0], ~trial[pdlf_pkg::GAIN_W+1]};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == pdlf_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quot_ff;
   assign status   = '{busy: busy_ff, done: done_ff};

endmodule

@@ hdl/pd_line_follow_motor_mix_unit.sv @@
// Top level of the PD line-follow controller with a two-motor speed mix.
//
// Usage: each request beat carries one line position sample. While enabled,
// the block answers every sample with exactly one response beat holding the
// left and right motor speeds; while disabled, samples are accepted and dropped.
// A zero gain denominator yields a beat with both speeds zero and halted set,
// and leaves the stored previous error untouched.
// Sequence: for a normal sample, each gain term takes a multiply step, the
// divider and a handoff step; then one mix step loads the response register.
// The single shared restoring divider works one quotient bit per cycle. A
// halted sample goes from acceptance straight to the mix step; a disabled one
// is dropped at acceptance.
// Flow: one sample at a time; req.ready is high only while idle.
// Stall: the finished result sits in an output register; a new sample can be
// accepted while it waits. If the sink still stalls when the next result is
// ready, the sequencer holds in the mix step until the register frees.
// Reset: synchronous; clears the sequencer, the output valid, the previous
// error and the registers (speed_limit to 255, all others to 0).
// Registers are written through csr_we/csr_index/csr_wdata by the user only
// while idle; the block itself does not enforce this.
module pd_line_follow_motor_mix_unit #(
   parameter int CENTER_POSITION = pdlf_pkg::CENTER_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   pdlf_req_if.sink                           req_bus,
   pdlf_rsp_if.source                         rsp_bus,
   input  logic                               csr_we,
   input  logic [pdlf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pdlf_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam logic signed [pdlf_pkg::CENTER_W+1:0] CENTER_S =
      (pdlf_pkg::CENTER_W+2)'(CENTER_POSITION);

   // configuration registers
   logic                              enable_ff;
   logic [pdlf_pkg::SPEED_W-1:0]      speed_limit_ff;
   logic [pdlf_pkg::GAIN_W-1:0]       prop_num_ff, prop_den_ff;
   logic [pdlf_pkg::GAIN_W-1:0]       deriv_num_ff, deriv_den_ff;

   // sequencer and datapath
   pdlf_pkg::state_type               state_ff, state_in;
   logic signed [pdlf_pkg::ERR_W-1:0]   err_ff, err_in;
   logic signed [pdlf_pkg::ERR_W-1:0]   prev_err_ff;
   logic signed [pdlf_pkg::DERIV_W-1:0] deriv_ff, deriv_in;
   logic signed [pdlf_pkg::SUM_W-1:0]   acc_ff, acc_in;
   logic                              halt_ff;
   logic                              neg_ff;

   // response register
   logic                              rsp_valid_ff;
   logic [pdlf_pkg::SPEED_W-1:0]      left_ff, left_in;
   logic [pdlf_pkg::SPEED_W-1:0]      right_ff, right_in;
   logic                              halted_ff;

   logic                              accept;
   logic                              den_zero;
   logic                              rsp_free;
   logic                              mix_load;
   logic signed [pdlf_pkg::CENTER_W+1:0] pos_diff;

   // shared multiplier and divider port
   logic                              mul_sel_d;
   logic                              div_start;
   logic signed [pdlf_pkg::DERIV_W-1:0] mul_a;
   logic [pdlf_pkg::GAIN_W-1:0]       mul_b;
   logic [pdlf_pkg::GAIN_W-1:0]       div_den;
   logic signed [pdlf_pkg::PROD_W-1:0]  prod;
   logic [pdlf_pkg::PROD_W-1:0]       prod_abs;
   logic [pdlf_pkg::QUOT_W-1:0]       quot;
   logic signed [pdlf_pkg::SUM_W-1:0]   quot_s;
   pdlf_pkg::div_status_type          div_stat;

   // clamp and mix
   logic signed [pdlf_pkg::SUM_W-1:0]   limit_s;
   logic signed [pdlf_pkg::DIFF_W-1:0]  diff;

   assign accept   = req_bus.valid && req_bus.ready;
   assign den_zero = (prop_den_ff == '0) || (deriv_den_ff == '0);
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign mix_load = (state_ff == pdlf_pkg::ST_MIX) && rsp_free;

   // ---------------------------------------------------------------------
   // Configuration writes
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= 1'b0;
         speed_limit_ff <= pdlf_pkg::SPEED_RESET;
         prop_num_ff    <= '0;
         prop_den_ff    <= '0;
         deriv_num_ff   <= '0;
         deriv_den_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            pdlf_pkg::CSR_ENABLE:      enable_ff      <= csr_wdata[0];
            pdlf_pkg::CSR_SPEED_LIMIT: speed_limit_ff <= csr_wdata;
            pdlf_pkg::CSR_PROP_NUM:    prop_num_ff    <= csr_wdata[pdlf_pkg::GAIN_W-1:0];
            pdlf_pkg::CSR_PROP_DEN:    prop_den_ff    <= csr_wdata[pdlf_pkg::GAIN_W-1:0];
            pdlf_pkg::CSR_DERIV_NUM:   deriv_num_ff   <= csr_wdata[pdlf_pkg::GAIN_W-1:0];
            pdlf_pkg::CSR_DERIV_DEN:   deriv_den_ff   <= csr_wdata[pdlf_pkg::GAIN_W-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Error and derivative, formed at acceptance
   // ---------------------------------------------------------------------
   assign pos_diff = $signed({{(pdlf_pkg::CENTER_W+2-pdlf_pkg::POS_W){1'b0}},
                              req_bus.sensor_pos}) - CENTER_S;

   always_comb begin
      // saturate to the 12-bit signed range
      if (pos_diff < -(pdlf_pkg::CENTER_W+2)'(2048)) begin
         err_in = -12'sd2048;
      end else if (pos_diff > (pdlf_pkg::CENTER_W+2)'(2047)) begin
         err_in = 12'sd2047;
      end else begin
         err_in = pos_diff[pdlf_pkg::ERR_W-1:0];
      end
      deriv_in = (pdlf_pkg::DERIV_W)'(err_in) - (pdlf_pkg::DERIV_W)'(prev_err_ff);
   end

   // ---------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pdlf_pkg::ST_IDLE: begin
            if (accept && enable_ff) begin
               state_in = den_zero ? pdlf_pkg::ST_MIX : pdlf_pkg::ST_MUL_P;
            end
         end
         pdlf_pkg::ST_MUL_P: state_in = pdlf_pkg::ST_DIV_P;
         pdlf_pkg::ST_DIV_P: begin
            if (div_stat.done) begin
               state_in = pdlf_pkg::ST_MUL_D;
            end
         end
         pdlf_pkg::ST_MUL_D: state_in = pdlf_pkg::ST_DIV_D;
         pdlf_pkg::ST_DIV_D: begin
            if (div_stat.done) begin
               state_in = pdlf_pkg::ST_MIX;
            end
         end
         pdlf_pkg::ST_MIX: begin
            if (rsp_free) begin
               state_in = pdlf_pkg::ST_IDLE;
            end
         end
         default: state_in = pdlf_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer: outputs
   // ---------------------------------------------------------------------
   always_comb begin
      req_bus.ready = 1'b0;
      div_start     = 1'b0;
      mul_sel_d     = 1'b0;
      case (state_ff)
         pdlf_pkg::ST_IDLE:  req_bus.ready = 1'b1;
         pdlf_pkg::ST_MUL_P: div_start = 1'b1;
         pdlf_pkg::ST_MUL_D: begin
            div_start = 1'b1;
            mul_sel_d = 1'b1;
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------
   // Shared multiplier feeding the divider
   // ---------------------------------------------------------------------
   assign mul_a   = mul_sel_d ? deriv_ff : (pdlf_pkg::DERIV_W)'(err_ff);
   assign mul_b   = mul_sel_d ? deriv_num_ff : prop_num_ff;
   assign div_den = mul_sel_d ? deriv_den_ff : prop_den_ff;
   assign prod    = mul_a * $signed({1'b0, mul_b});
   assign prod_abs = prod[pdlf_pkg::PROD_W-1] ? -prod : prod;

   pdlf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_abs[pdlf_pkg::MAG_W-1:0]),
      .divisor  (div_den),
      .quotient (quot),
      .status   (div_stat)
   );

   // restore the sign: truncation toward zero
   assign quot_s = neg_ff ? -(pdlf_pkg::SUM_W)'(quot) : (pdlf_pkg::SUM_W)'(quot);

   always_comb begin
      acc_in = acc_ff;
      if (div_stat.done && state_ff == pdlf_pkg::ST_DIV_P) begin
         acc_in = quot_s;
      end else if (div_stat.done && state_ff == pdlf_pkg::ST_DIV_D) begin
         acc_in = acc_ff + quot_s;
      end
   end

   // ---------------------------------------------------------------------
   // Clamp and mix
   // ---------------------------------------------------------------------
   assign limit_s = $signed({{(pdlf_pkg::SUM_W-pdlf_pkg::SPEED_W){1'b0}}, speed_limit_ff});

   always_comb begin
      if (acc_ff < -limit_s) begin
         diff = -(pdlf_pkg::DIFF_W)'(limit_s);
      end else if (acc_ff > limit_s) begin
         diff = (pdlf_pkg::DIFF_W)'(limit_s);
      end else begin
         diff = acc_ff[pdlf_pkg::DIFF_W-1:0];
      end
      if (halt_ff) begin
         left_in  = '0;
         right_in = '0;
      end else if (diff < 0) begin
         // slow the left wheel
         left_in  = speed_limit_ff + diff[pdlf_pkg::SPEED_W-1:0];
         right_in = speed_limit_ff;
      end else begin
         left_in  = speed_limit_ff;
         right_in = speed_limit_ff - diff[pdlf_pkg::SPEED_W-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         err_ff   <= err_in;
         deriv_ff <= deriv_in;
         halt_ff  <= den_zero;
      end
      if (div_start) begin
         neg_ff <= prod[pdlf_pkg::PROD_W-1];
      end
      acc_ff <= acc_in;
      if (mix_load) begin
         left_ff   <= left_in;
         right_ff  <= right_in;
         halted_ff <= halt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pdlf_pkg::ST_IDLE;
         prev_err_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // advance the stored error only on a computed sample
         if (accept && enable_ff && !den_zero) begin
            prev_err_ff <= err_in;
         end
         if (mix_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.left_speed  = left_ff;
   assign rsp_bus.right_speed = right_ff;
   assign rsp_bus.halted      = halted_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_halt_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.halted |-> rsp_bus.left_speed == '0 && rsp_bus.right_speed == '0)
      else $error("halted beat carries nonzero speed");

   a_one_wheel_full: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.halted |->
         rsp_bus.left_speed == speed_limit_ff || rsp_bus.right_speed == speed_limit_ff)
      else $error("neither wheel runs at the speed limit");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider restarted while busy");

   a_drop_disabled: assert property (@(posedge clock) disable iff (reset)
      accept && !enable_ff |=> state_ff == pdlf_pkg::ST_IDLE && !$rose(rsp_valid_ff))
      else $error("disabled sample produced work");

endmodule

@@ sim/tb.sv @@
// Self-checking bench for the PD line-follow motor mix unit: directed and random sample beats.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS   = 1050;  // sample beats in the random part
   localparam int SETTLE_CYCLES  = 60;    // covers one full computation
   localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles before the run is called hung
   localparam int MAX_REPORTS    = 10;
   localparam int IDLE_PERCENT   = 37;
   localparam int POS_MAX        = 4000;  // top of the sensor's normal range
   localparam int POS_TOP        = (1 << pdlf_pkg::POS_W) - 1;
   localparam int ERR_MAX        = (1 << (pdlf_pkg::ERR_W - 1)) - 1;
   localparam int ERR_MIN        = -(1 << (pdlf_pkg::ERR_W - 1));
   localparam int GAIN_MAX       = (1 << pdlf_pkg::GAIN_W) - 1;
   localparam int SPEED_MAX      = (1 << pdlf_pkg::SPEED_W) - 1;

   // Indexes past the register list: writes there must change nothing.
   localparam logic [pdlf_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [pdlf_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [pdlf_pkg::SPEED_W-1:0] left_speed;
      logic [pdlf_pkg::SPEED_W-1:0] right_speed;
      logic                         halted;
   } motor_cmd_type;

   // Mirror of the controller: register copies, the stored error, and the
   // queue of motor commands still owed by the block.
   class motor_mix_scoreboard;
      bit                                enable;
      bit [pdlf_pkg::SPEED_W-1:0]        speed_limit;
      bit [pdlf_pkg::GAIN_W-1:0]         prop_num;
      bit [pdlf_pkg::GAIN_W-1:0]         prop_den;
      bit [pdlf_pkg::GAIN_W-1:0]         deriv_num;
      bit [pdlf_pkg::GAIN_W-1:0]         deriv_den;
      logic signed [pdlf_pkg::ERR_W-1:0] last_error;
      motor_cmd_type                     cmd_q[$];
      int                                failures;

      function new();
         enable      = 1'b0;
         speed_limit = pdlf_pkg::SPEED_RESET;
         prop_num    = '0;
         prop_den    = '0;
         deriv_num   = '0;
         deriv_den   = '0;
         last_error  = '0;
         failures    = 0;
      endfunction

      function void set_register(logic [pdlf_pkg::CSR_IDX_W-1:0] index,
                                 logic [pdlf_pkg::CSR_DATA_W-1:0] data);
         case (index)
            pdlf_pkg::CSR_ENABLE:      enable      = data[0];
            pdlf_pkg::CSR_SPEED_LIMIT: speed_limit = data;
            pdlf_pkg::CSR_PROP_NUM:    prop_num    = data[pdlf_pkg::GAIN_W-1:0];
            pdlf_pkg::CSR_PROP_DEN:    prop_den    = data[pdlf_pkg::GAIN_W-1:0];
            pdlf_pkg::CSR_DERIV_NUM:   deriv_num   = data[pdlf_pkg::GAIN_W-1:0];
            pdlf_pkg::CSR_DERIV_DEN:   deriv_den   = data[pdlf_pkg::GAIN_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return cmd_q.size();
      endfunction

      // Work out the motor command owed for one accepted sample.
      function void note_sample(logic [pdlf_pkg::POS_W-1:0] position);
         int            err;
         int            slope;
         int            drive;
         int            limit;
         motor_cmd_type cmd;
         if (!enable) return;
         cmd = '0;
         if (prop_den == 0 || deriv_den == 0) begin
            // zero gain denominator: stop both wheels, keep the stored error
            cmd.halted = 1'b1;
            cmd_q.push_back(cmd);
            return;
         end
         err = int'(position) - pdlf_pkg::CENTER_DEFAULT;
         if (err > ERR_MAX) err = ERR_MAX;
         if (err < ERR_MIN) err = ERR_MIN;
         slope      = err - int'(last_error);
         last_error = err[pdlf_pkg::ERR_W-1:0];
         drive = (err * int'(prop_num)) / int'(prop_den)
               + (slope * int'(deriv_num)) / int'(deriv_den);
         limit = int'(speed_limit);
         if (drive > limit)  drive = limit;
         if (drive < -limit) drive = -limit;
         if (drive < 0) begin
            cmd.left_speed  = pdlf_pkg::SPEED_W'(limit + drive);
            cmd.right_speed = pdlf_pkg::SPEED_W'(limit);
         end else begin
            cmd.left_speed  = pdlf_pkg::SPEED_W'(limit);
            cmd.right_speed = pdlf_pkg::SPEED_W'(limit - drive);
         end
         cmd_q.push_back(cmd);
      endfunction

      function void flag_failure(string what, motor_cmd_type want, motor_cmd_type got);
         failures++;
         if (failures <= MAX_REPORTS)
            $display("%0t: %s: expected left %0d right %0d halted %0b, ",
                     $time, what, want.left_speed, want.right_speed, want.halted,
                     "got left %0d right %0d halted %0b",
                     got.left_speed, got.right_speed, got.halted);
      endfunction

      // Compare one response beat with the oldest owed command.
      function void check_beat(motor_cmd_type got);
         motor_cmd_type want;
         if (cmd_q.size() == 0) begin
            flag_failure("response beat with nothing owed", '0, got);
            return;
         end
         want = cmd_q.pop_front();
         if (got.left_speed !== want.left_speed || got.right_speed !== want.right_speed ||
             got.halted !== want.halted)
            flag_failure("motor command mismatch", want, got);
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic [pdlf_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [pdlf_pkg::CSR_DATA_W-1:0] csr_wdata;

   pdlf_req_if req_bus ();
   pdlf_rsp_if rsp_bus ();

   pd_line_follow_motor_mix_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   motor_mix_scoreboard sb;
   bit send_idle;    // sender may insert gaps
   bit recv_idle;    // receiver may stall
   int quiet_cycles;

   // 10 ns clock: hold high, then low.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: drop ready at random about 37 percent of the time while
   // stalling is on; hold it high otherwise.
   always @(negedge clock) begin
      rsp_bus.ready <= !(recv_idle && $urandom_range(0, 99) < IDLE_PERCENT);
   end

   // Check every accepted response beat against the oldest owed command.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_beat('{rsp_bus.left_speed, rsp_bus.right_speed, rsp_bus.halted});
   end

   // Watchdog: count cycles with no beat on either channel; give up at the limit.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Write one register; leave the write enable high so back-to-back writes
   // do not toggle it within a time step.
   task automatic write_register(input logic [pdlf_pkg::CSR_IDX_W-1:0] index,
                                 input logic [pdlf_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      sb.set_register(index, data);
      @(negedge clock);
   endtask

   // Load all six registers, optionally poking a spare index first, then
   // drop the write enable.
   task automatic load_settings(input logic [pdlf_pkg::CSR_DATA_W-1:0] en,
                                input logic [pdlf_pkg::CSR_DATA_W-1:0] spd,
                                input logic [pdlf_pkg::CSR_DATA_W-1:0] pn,
                                input logic [pdlf_pkg::CSR_DATA_W-1:0] pd,
                                input logic [pdlf_pkg::CSR_DATA_W-1:0] dn,
                                input logic [pdlf_pkg::CSR_DATA_W-1:0] dd,
                                input bit poke_spare);
      if (poke_spare)
         write_register($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO,
                        pdlf_pkg::CSR_DATA_W'($urandom));
      write_register(pdlf_pkg::CSR_ENABLE, en);
      write_register(pdlf_pkg::CSR_SPEED_LIMIT, spd);
      write_register(pdlf_pkg::CSR_PROP_NUM, pn);
      write_register(pdlf_pkg::CSR_PROP_DEN, pd);
      write_register(pdlf_pkg::CSR_DERIV_NUM, dn);
      write_register(pdlf_pkg::CSR_DERIV_DEN, dd);
      csr_we <= 1'b0;
   endtask

   // Offer one sample beat. Called at a falling edge; returns at the falling
   // edge after the beat is taken, with valid still high so the next beat can
   // follow without a gap.
   task automatic send_sample(input logic [pdlf_pkg::POS_W-1:0] position);
      if (send_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < IDLE_PERCENT);
      end
      req_bus.valid      <= 1'b1;
      req_bus.sensor_pos <= position;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_sample(position);
      @(negedge clock);
   endtask

   // Drop valid, wait for every owed command, then let any dropped or
   // in-flight work finish before the registers change.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Next sample: mostly a drifting track near the last one, some jumps
   // around the center, some anywhere, and a few past the sensor range.
   function automatic logic [pdlf_pkg::POS_W-1:0] next_position(
         logic [pdlf_pkg::POS_W-1:0] last);
      int pick;
      int p;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         p = int'(last) + int'($urandom_range(0, 120)) - 60;
      else if (pick < 85)
         p = pdlf_pkg::CENTER_DEFAULT + int'($urandom_range(0, 600)) - 300;
      else if (pick < 95)
         p = int'($urandom_range(0, POS_MAX));
      else
         p = int'($urandom_range(POS_MAX + 1, POS_TOP));
      if (p < 0) p = 0;
      if (p > POS_TOP) p = POS_TOP;
      return pdlf_pkg::POS_W'(p);
   endfunction

   // Gain register value with a stray top bit that the register must drop.
   function automatic logic [pdlf_pkg::CSR_DATA_W-1:0] pick_gain(int zero_pct);
      int                              pick;
      logic [pdlf_pkg::CSR_DATA_W-1:0] v;
      pick = $urandom_range(0, 99);
      if (pick < zero_pct)           v = '0;
      else if (pick < zero_pct + 10) v = pdlf_pkg::CSR_DATA_W'(GAIN_MAX);
      else if (pick < zero_pct + 55) v = pdlf_pkg::CSR_DATA_W'($urandom_range(1, 16));
      else                           v = pdlf_pkg::CSR_DATA_W'($urandom_range(1, GAIN_MAX));
      v[pdlf_pkg::CSR_DATA_W-1] = $urandom_range(0, 1);
      return v;
   endfunction

   initial begin
      logic [pdlf_pkg::POS_W-1:0]      position;
      logic [pdlf_pkg::CSR_DATA_W-1:0] en;
      logic [pdlf_pkg::CSR_DATA_W-1:0] spd;
      int                              live_items;
      int                              phase;
      int                              count;
      int                              pick;

      sb        = new();
      send_idle = 1'b1;
      recv_idle = 1'b1;
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid      = 1'b0;
      req_bus.sensor_pos = '0;
      rsp_bus.ready      = 1'b0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Disabled out of reset: beats are taken and dropped.
      send_sample(12'd0);
      send_sample(pdlf_pkg::POS_W'(POS_TOP));
      drain();

      // Enabled with both denominators still zero: halt beats.
      load_settings(8'd1, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
      send_sample(12'd0);
      send_sample(12'(pdlf_pkg::CENTER_DEFAULT));
      drain();

      // Largest gains: drive the clamp both ways, cover the position extremes.
      load_settings(8'd1, 8'd255, 8'd127, 8'd1, 8'd127, 8'd1, 1'b1);
      send_sample(12'd0);
      send_sample(12'(POS_MAX));
      send_sample(pdlf_pkg::POS_W'(POS_TOP));
      send_sample(12'(pdlf_pkg::CENTER_DEFAULT));
      send_sample(12'(pdlf_pkg::CENTER_DEFAULT));
      send_sample(12'(pdlf_pkg::CENTER_DEFAULT - 1));
      send_sample(12'(pdlf_pkg::CENTER_DEFAULT + 1));
      send_sample(12'h555);
      send_sample(12'hAAA);
      send_sample(12'h800);
      drain();

      // Zero speed limit: both wheels stop whatever the error.
      load_settings(8'd1, 8'd0, 8'd127, 8'd1, 8'd127, 8'd1, 1'b1);
      send_sample(12'(POS_MAX));
      send_sample(12'd0);
      drain();

      // Smallest nonzero gains, truncation toward zero on both signs.
      load_settings(8'd1, 8'd200, 8'd1, 8'd127, 8'd1, 8'd127, 1'b0);
      send_sample(12'd3000);
      send_sample(12'd1000);
      send_sample(12'd2100);
      drain();

      // Zero numerators: no steering at all.
      load_settings(8'd1, 8'd128, 8'd0, 8'd5, 8'd0, 8'd9, 1'b0);
      send_sample(12'd3500);
      drain();

      // One denominator zero at a time; the stored error must survive.
      load_settings(8'd1, 8'd255, 8'd64, 8'd0, 8'd32, 8'd7, 1'b0);
      send_sample(12'd3000);
      drain();
      load_settings(8'd1, 8'd255, 8'd64, 8'd7, 8'd32, 8'd0, 1'b0);
      send_sample(12'd1000);
      drain();
      load_settings(8'd1, 8'd255, 8'd9, 8'd4, 8'd100, 8'd3, 1'b0);
      send_sample(12'd2500);
      send_sample(12'd1500);
      drain();

      // Random part: phases of fresh settings, each a run of tracked samples.
      // Every sixth phase is a long stretch with no gaps and no stalls.
      live_items = 0;
      phase      = 0;
      position   = 12'(pdlf_pkg::CENTER_DEFAULT);
      while (live_items < RANDOM_ITEMS) begin
         phase++;
         send_idle = (phase % 6 != 3);
         recv_idle = (phase % 6 != 3);
         en        = pdlf_pkg::CSR_DATA_W'($urandom) & ~pdlf_pkg::CSR_DATA_W'(1);
         en[0]     = ($urandom_range(0, 9) != 0);
         pick      = $urandom_range(0, 99);
         if (pick < 10)      spd = '0;
         else if (pick < 20) spd = pdlf_pkg::CSR_DATA_W'(SPEED_MAX);
         else                spd = pdlf_pkg::CSR_DATA_W'($urandom_range(0, SPEED_MAX));
         load_settings(en, spd, pick_gain(10), pick_gain(6), pick_gain(10), pick_gain(6),
                       $urandom_range(0, 4) == 0);
         count = send_idle ? $urandom_range(15, 60) : 150;
         repeat (count) begin
            position = next_position(position);
            send_sample(position);
            live_items++;
         end
         drain();
      end

      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/pdlf_pkg.sv
hdl/pdlf_req_if.sv
hdl/pdlf_rsp_if.sv
hdl/pdlf_div.sv
hdl/pd_line_follow_motor_mix_unit.sv
sim/tb.sv
